[rtl/core/lz4d_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lz4d_pkg: shared definitions for the LZ4 block decoder
// Result kind codes, default sizes and the step record that the parser hands
// to the datapath for each processed input item.
// ----------------------------------------------------------------------------
package lz4d_pkg;

  // Default sizing of the history window and the length counters.
  localparam int WINDOW_BYTES_DEF = 65536;
  localparam int COUNT_BITS_DEF   = 16;

  // Token nibble value that announces extension bytes, and the minimum match.
  localparam logic [3:0] NIB_ESC   = 4'hf;
  localparam logic [3:0] MIN_MATCH = 4'd4;

  // Extension bytes of this value continue the length.
  localparam logic [7:0] EXT_MORE = 8'hff;

  // Result kinds.
  localparam logic [1:0] KIND_LIT    = 2'd0;
  localparam logic [1:0] KIND_MATCH  = 2'd1;
  localparam logic [1:0] KIND_REFUSE = 2'd2;

  // What one processed item does to the datapath.
  typedef struct packed {
    logic       emit;   // the item produces a result
    logic [1:0] kind;   // result kind
    logic [7:0] lit;    // literal byte (also the refusal byte, zero)
    logic       last;   // final byte of the stream
    logic       match;  // the result byte comes from the history window
    logic       store;  // the result byte is written to the history window
  } step_t;

endpackage
`default_nettype wire

[rtl/core/lz4d_parse.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lz4d_parse: LZ4 sequence parser
// Holds the decoder state and works out, for one registered input item, the
// result it causes, the history addresses it uses and the next state.
// ----------------------------------------------------------------------------
module lz4d_parse
  import lz4d_pkg::*;
#(
  parameter int ADDR_BITS  = $clog2(WINDOW_BYTES_DEF),
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic                 mode,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 final_input,
  output step_t                     step,
  output logic      [ADDR_BITS-1:0] waddr,
  output logic      [ADDR_BITS-1:0] raddr
);

  // Parser phases.
  localparam logic [2:0] PH_TOKEN  = 3'd0;
  localparam logic [2:0] PH_LITEXT = 3'd1;
  localparam logic [2:0] PH_LITS   = 3'd2;
  localparam logic [2:0] PH_OFFLO  = 3'd3;
  localparam logic [2:0] PH_OFFHI  = 3'd4;
  localparam logic [2:0] PH_MATEXT = 3'd5;
  localparam logic [2:0] PH_COPY   = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  logic [2:0]            phase, phase_next;
  logic [3:0]            match_nibble, match_nibble_next;
  logic [COUNT_BITS-1:0] remaining, remaining_next;
  logic [15:0]           match_offset, match_offset_next;
  logic [ADDR_BITS-1:0]  write_pos, write_pos_next;
  logic                  end_seen, end_seen_next;

  logic [COUNT_BITS:0]   ext_sum;
  logic [COUNT_BITS-1:0] ext_sat;
  logic [COUNT_BITS-1:0] rem_dec;
  logic [COUNT_BITS-1:0] match_len;

  // Length arithmetic: saturating extension add and floored decrement.
  assign ext_sum = {1'b0, remaining} + (COUNT_BITS + 1)'(data_byte);
  assign ext_sat = ext_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : ext_sum[COUNT_BITS-1:0];
  assign rem_dec = (remaining != '0) ? remaining - 1'b1 : '0;
  assign match_len = COUNT_BITS'(match_nibble) + COUNT_BITS'(MIN_MATCH);

  // The item writes at the current position; a match reads offset bytes back.
  assign waddr = write_pos;
  assign raddr = write_pos - match_offset[ADDR_BITS-1:0];

  // Next-state and result decode for the item in the input register.
  always_comb begin
    phase_next        = phase;
    match_nibble_next = match_nibble;
    remaining_next    = remaining;
    match_offset_next = match_offset;
    write_pos_next    = write_pos;
    end_seen_next     = end_seen;
    step              = '0;

    if (phase != PH_DONE) begin
      if (mode) begin
        // Copy tick: only meaningful while a match is pending.
        if (phase == PH_COPY) begin
          step.emit      = 1'b1;
          step.kind      = KIND_MATCH;
          step.match     = 1'b1;
          step.store     = 1'b1;
          write_pos_next = write_pos + 1'b1;
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_TOKEN;
          end
        end
      end else if (phase == PH_COPY) begin
        // Data while a copy is pending is refused and not consumed.
        step.emit = 1'b1;
        step.kind = KIND_REFUSE;
      end else begin
        if (final_input) begin
          end_seen_next = 1'b1;
        end
        case (phase)
          PH_TOKEN: begin
            match_nibble_next = data_byte[3:0];
            if (data_byte[7:4] == NIB_ESC) begin
              remaining_next = COUNT_BITS'(NIB_ESC);
              phase_next     = PH_LITEXT;
            end else if (data_byte[7:4] != 4'd0) begin
              remaining_next = COUNT_BITS'(data_byte[7:4]);
              phase_next     = PH_LITS;
            end else begin
              phase_next = PH_OFFLO;
            end
          end
          PH_LITEXT: begin
            remaining_next = ext_sat;
            if (data_byte != EXT_MORE) begin
              phase_next = PH_LITS;
            end
          end
          PH_LITS: begin
            step.emit      = 1'b1;
            step.kind      = KIND_LIT;
            step.lit       = data_byte;
            step.store     = 1'b1;
            write_pos_next = write_pos + 1'b1;
            remaining_next = rem_dec;
            if (rem_dec == '0) begin
              if (end_seen_next) begin
                phase_next = PH_DONE;
                step.last  = 1'b1;
              end else begin
                phase_next = PH_OFFLO;
              end
            end
          end
          PH_OFFLO: begin
            match_offset_next = {8'h00, data_byte};
            phase_next        = PH_OFFHI;
          end
          PH_OFFHI: begin
            match_offset_next = {data_byte, match_offset[7:0]};
            remaining_next    = match_len;
            if (match_nibble == NIB_ESC) begin
              phase_next = PH_MATEXT;
            end else begin
              phase_next = PH_COPY;
            end
          end
          PH_MATEXT: begin
            remaining_next = ext_sat;
            if (data_byte != EXT_MORE) begin
              phase_next = PH_COPY;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  // State registers advance when the item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TOKEN;
      match_nibble <= '0;
      remaining    <= '0;
      match_offset <= '0;
      write_pos    <= '0;
      end_seen     <= 1'b0;
    end else if (go) begin
      phase        <= phase_next;
      match_nibble <= match_nibble_next;
      remaining    <= remaining_next;
      match_offset <= match_offset_next;
      write_pos    <= write_pos_next;
      end_seen     <= end_seen_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/lz4_block_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lz4_block_decoder: streaming LZ4 block decompressor
// Takes compressed bytes and copy ticks, returns literal and match bytes.
// ----------------------------------------------------------------------------
// The decoder accepts one item per clock cycle unless in_stall is high: a
// compressed byte (mode 0) or a copy tick (mode 1). Each item that yields a
// result passes through an input register, a stage holding the registered
// read of the history window, and the output register, from which it
// transfers when the output side does not stall. The window memory has one
// read and one write port and a byte written by the previous item is
// forwarded, so overlapping matches (for example an offset of one) run at
// full rate. WINDOW_BYTES must be a power of two. The window is not cleared
// after reset: a match may only refer to bytes that the stream has already
// produced. Data offered while a match is pending gets a refusal result and
// must be offered again after the copy.
// ----------------------------------------------------------------------------
module lz4_block_decoder
  import lz4d_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       mode,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_input,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_byte,
  output logic      [1:0] kind,
  output logic            stream_end
);

  localparam int ADDR_BITS = $clog2(WINDOW_BYTES);

  // Input register.
  logic       s1_valid;
  logic       s1_mode;
  logic [7:0] s1_byte;
  logic       s1_fin;

  // Memory stage.
  logic                 s2_valid;
  logic [1:0]           s2_kind;
  logic [7:0]           s2_lit;
  logic                 s2_last;
  logic                 s2_match;
  logic                 s2_store;
  logic                 s2_fwd_sel;
  logic [7:0]           s2_fwd;
  logic [ADDR_BITS-1:0] s2_waddr;
  logic [7:0]           s2_byte;
  logic [7:0]           rdata;

  logic [7:0] history [WINDOW_BYTES];

  step_t                step;
  logic [ADDR_BITS-1:0] waddr;
  logic [ADDR_BITS-1:0] raddr;

  logic out_free;
  logic s2_leave;
  logic s1_go;
  logic in_take;
  logic s2_write;

  // Flow control: each stage moves when the one after it has room.
  assign out_free = !out_valid || !out_stall;
  assign s2_leave = s2_valid && out_free;
  assign s1_go    = s1_valid && (!s2_valid || out_free);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign s2_write = s2_leave && s2_store;

  // Input register captures each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode <= mode;
      s1_byte <= data_byte;
      s1_fin  <= final_input;
    end
  end

  // Sequence parser and decoder state.
  lz4d_parse #(
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .go          (s1_go),
    .mode        (s1_mode),
    .data_byte   (s1_byte),
    .final_input (s1_fin),
    .step        (step),
    .waddr       (waddr),
    .raddr       (raddr)
  );

  // Memory stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go) begin
      s2_valid <= step.emit;
    end else if (s2_leave) begin
      s2_valid <= 1'b0;
    end
  end

  // Memory stage payload. A byte being written this cycle at the read address
  // is forwarded, since the array returns the old contents.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_kind    <= step.kind;
      s2_lit     <= step.lit;
      s2_last    <= step.last;
      s2_match   <= step.match;
      s2_store   <= step.store;
      s2_waddr   <= waddr;
      s2_fwd_sel <= s2_write && (s2_waddr == raddr);
      s2_fwd     <= s2_byte;
    end
  end

  assign s2_byte = s2_match ? (s2_fwd_sel ? s2_fwd : rdata) : s2_lit;

  // History window: one write as a byte leaves the memory stage, one read
  // as a match tick enters it.
  always_ff @(posedge clk) begin
    if (s2_write) begin
      history[s2_waddr] <= s2_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && step.match) begin
      rdata <= history[raddr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_leave) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_leave) begin
      out_byte   <= s2_byte;
      kind       <= s2_kind;
      stream_end <= s2_last;
    end
  end

endmodule
`default_nettype wire

[rtl/core/lz4d_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lz4d_checker: port-level checks for the LZ4 block decoder
// Watches the top-level ports and flags handshake and result-format slips.
// ----------------------------------------------------------------------------
module lz4d_checker
  import lz4d_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] kind,
  input wire logic       stream_end
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(stream_end))
    else $error("result changed while stalled");

  // The input side only stalls when the output register holds a result.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output");

  // A refusal carries a zero byte and never ends the stream.
  a_refuse_fmt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REFUSE) |-> (out_byte == 8'h00) && !stream_end)
    else $error("malformed refusal result");

  // The stream ends only on a literal byte.
  a_end_on_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> kind == KIND_LIT)
    else $error("stream end on a non-literal result");

  // Nothing follows the final byte.
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && stream_end |=> !out_valid)
    else $error("result after the end of the stream");

endmodule

bind lz4_block_decoder lz4d_checker u_lz4d_checker (.*);
`default_nettype wire
